[rtl/core/assert_macros.svh]
// Assertion macros for the arm Jacobian RTL.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property holds on every clock edge outside reset
`define SRJ_ASSERT(lbl, clk, rst_n, prop) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// trigger on one edge implies result on the next
`define SRJ_ASSERT_NEXT(lbl, clk, rst_n, trig, res) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (res)) \
    else $error("assertion failed");
`else
`define SRJ_ASSERT(lbl, clk, rst_n, prop)
`define SRJ_ASSERT_NEXT(lbl, clk, rst_n, trig, res)
`endif
`endif

[rtl/core/srj_pkg.sv]
// Shared types, constants and arithmetic helpers for the arm Jacobian.
// No dependencies.
package srj_pkg;

    localparam int AQ_W  = 37;  // angle in Q.32 radians, q2+q3 included
    localparam int AR_W  = 38;  // range reduction
    localparam int Z_W   = 36;  // CORDIC residual angle
    localparam int XY_W  = 33;  // CORDIC x/y, Q1.30 with headroom
    localparam int NROWS = 6;

    typedef logic signed [31:0] unit_t;
    typedef logic signed [47:0] val_t;
    typedef logic [30:0]        creg_t;

    localparam logic signed [AR_W-1:0] PI_Q32      = 38'sd13493037705;
    localparam logic signed [AR_W-1:0] HALF_PI_Q32 = 38'sd6746518852;
    localparam logic signed [AR_W-1:0] TWO_PI_Q32  = 38'sd26986075409;
    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
    localparam unit_t                  ONE_Q30     = 32'sd1073741824;
    localparam logic [2:0]             LAST_ROW    = 3'd5;

    localparam int ST_BACKWARD = 0;
    localparam int ST_FLIP     = 1;
    localparam int ST_ELBOW    = 2;
    localparam int ST_WRIST    = 3;
    localparam int ST_EXTENDED = 4;
    localparam int ST_PARALLEL = 5;

    typedef enum logic [2:0] {
        REG_BASE_HEIGHT   = 3'd0,
        REG_UPPER_ARM     = 3'd1,
        REG_FOREARM       = 3'd2,
        REG_REACH_LIMIT   = 3'd3,
        REG_WRIST_MARGIN  = 3'd4,
        REG_EXT_MARGIN    = 3'd5,
        REG_PARALLEL_MARG = 3'd6
    } reg_idx_t;

    typedef struct packed {
        creg_t l1;
        creg_t l2;
        creg_t l3;
        creg_t reach;
        creg_t wab_margin;
        creg_t ext_margin;
        creg_t pw_margin;
    } cfg_t;

    typedef struct packed {
        unit_t s1;
        unit_t c1;
        unit_t s2;
        unit_t c2;
        unit_t s23;
        unit_t c23;
        unit_t s4;
        unit_t c4;
        unit_t s5;
        unit_t c5;
    } trig_t;

    // atan(2^-i) in Q.32, rounded; elaboration only
    function automatic logic signed [Z_W-1:0] atan_q32(int i);
        real r;
        r = $atan(2.0 ** (-i)) * 4294967296.0;
        return Z_W'(longint'(r));
    endfunction

    // Q.30 factor times value, split into 24-bit high and 16-bit low parts of v
    function automatic val_t mulq(val_t t, val_t v);
        logic signed [35:0] tn;
        logic signed [39:0] vn;
        logic signed [23:0] hi;
        logic [15:0]        lo;
        logic signed [59:0] p_hi;
        logic signed [52:0] p_lo;
        logic signed [61:0] acc;
        tn   = t[35:0];
        vn   = v[39:0];
        hi   = vn[39:16];
        lo   = vn[15:0];
        p_hi = tn * hi;
        p_lo = tn * $signed({1'b0, lo});
        acc  = 62'(p_hi) + 62'(p_lo >>> 16) + 62'sd8192;
        return val_t'(acc >>> 14);
    endfunction

endpackage

[rtl/core/srj_cordic_lane.sv]
// One sine/cosine lane: range reduction then a pipelined rotation CORDIC.
// Depends on srj_pkg. The pipeline advances only while en is high.
module srj_cordic_lane
    import srj_pkg::*;
#(
    parameter int STEPS = 24
)
(
    input  logic                   clk,
    input  logic                   en,
    input  logic signed [AQ_W-1:0] angle,
    output unit_t                  sin_val,
    output unit_t                  cos_val
);

    localparam logic signed [XY_W-1:0] ONE_XY = XY_W'(ONE_Q30);

    logic signed [Z_W-1:0]  z_reg   [STEPS+1];
    logic signed [XY_W-1:0] x_reg   [STEPS+1];
    logic signed [XY_W-1:0] y_reg   [STEPS+1];
    logic                   neg_reg [STEPS+1];
    logic signed [AR_W-1:0] red_a;
    logic                   red_neg;
    logic signed [XY_W-1:0] fx, fy;
    unit_t                  sin_reg, cos_reg;

    // into [-pi, pi], then fold into [-pi/2, pi/2]
    always_comb
    begin
        red_a = AR_W'(angle);
        for (int k = 0; k < 4; k++)
        begin
            if (red_a > PI_Q32)
                red_a = red_a - TWO_PI_Q32;
            else if (red_a < -PI_Q32)
                red_a = red_a + TWO_PI_Q32;
        end
        red_neg = 1'b0;
        if (red_a > HALF_PI_Q32)
        begin
            red_a   = red_a - PI_Q32;
            red_neg = 1'b1;
        end
        else if (red_a < -HALF_PI_Q32)
        begin
            red_a   = red_a + PI_Q32;
            red_neg = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg[0]   <= red_a[Z_W-1:0];
            x_reg[0]   <= CORDIC_GAIN;
            y_reg[0]   <= '0;
            neg_reg[0] <= red_neg;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        localparam logic signed [Z_W-1:0] ANG = atan_q32(i);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ANG;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ANG;
                end
            end
        end
    end

    always_comb
    begin
        fx = neg_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
        fy = neg_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
        if (fx > ONE_XY)
            fx = ONE_XY;
        else if (fx < -ONE_XY)
            fx = -ONE_XY;
        if (fy > ONE_XY)
            fy = ONE_XY;
        else if (fy < -ONE_XY)
            fy = -ONE_XY;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= fy[31:0];
            cos_reg <= fx[31:0];
        end
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

[rtl/core/srj_jacobian.sv]
// Merge stage: combines the five lane results into the 36 Jacobian entries
// and the status bits over four product layers. Depends on srj_pkg.
module srj_jacobian
    import srj_pkg::*;
#(
    parameter int ENTRY_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  trig_t                  trig,
    input  logic                   q3_neg,
    input  logic                   q5_neg,
    input  cfg_t                   cfg,
    output logic                   out_valid,
    output logic [ENTRY_WIDTH-1:0] ent [NROWS][NROWS],
    output logic [5:0]             status
);

    localparam val_t EMAX = val_t'((64'sd1 <<< (ENTRY_WIDTH - 1)) - 64'sd1);
    localparam val_t EMIN = ~EMAX;
    localparam val_t ONE_V = val_t'(ONE_Q30);

    function automatic logic [ENTRY_WIDTH-1:0] sat(val_t v);
        if (v > EMAX)
            return EMAX[ENTRY_WIDTH-1:0];
        else if (v < EMIN)
            return EMIN[ENTRY_WIDTH-1:0];
        else
            return v[ENTRY_WIDTH-1:0];
    endfunction

    val_t l1, l2, l3;
    val_t s1, c1, s2, c2, s23, c23, s4, c4, s5, c5;
    logic [61:0] em2;

    assign l1  = val_t'(cfg.l1);
    assign l2  = val_t'(cfg.l2);
    assign l3  = val_t'(cfg.l3);
    assign s1  = val_t'(trig.s1);
    assign c1  = val_t'(trig.c1);
    assign s2  = val_t'(trig.s2);
    assign c2  = val_t'(trig.c2);
    assign s23 = val_t'(trig.s23);
    assign c23 = val_t'(trig.c23);
    assign s4  = val_t'(trig.s4);
    assign c4  = val_t'(trig.c4);
    assign s5  = val_t'(trig.s5);
    assign c5  = val_t'(trig.c5);
    assign em2 = cfg.ext_margin * cfg.ext_margin;

    // ---- layer 1: pairwise trig products and link terms
    logic v1_reg;
    val_t c4s5_reg, s4s5_reg, c1c23_reg, c1s23_reg, s1c23_reg, s1s23_reg;
    val_t c2l2_reg, c23l3_reg, s2l2_reg, s23l3_reg;
    val_t c1c4_reg, s1c4_reg, c23c5_reg, s23c5_reg, s23s4_reg;
    val_t s1_1_reg, c1_1_reg, s23_1_reg, c23_1_reg, s4_1_reg, c5_1_reg;
    val_t rhs_1_reg;
    logic [1:0] st_1_reg;
    logic st5_1_reg;
    val_t abs_s5;

    assign abs_s5 = (s5 < 0) ? -s5 : s5;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c4s5_reg  <= mulq(c4, s5);
            s4s5_reg  <= mulq(s4, s5);
            c1c23_reg <= mulq(c1, c23);
            c1s23_reg <= mulq(c1, s23);
            s1c23_reg <= mulq(s1, c23);
            s1s23_reg <= mulq(s1, s23);
            c2l2_reg  <= mulq(c2, l2);
            c23l3_reg <= mulq(c23, l3);
            s2l2_reg  <= mulq(s2, l2);
            s23l3_reg <= mulq(s23, l3);
            c1c4_reg  <= mulq(c1, c4);
            s1c4_reg  <= mulq(s1, c4);
            c23c5_reg <= mulq(c23, c5);
            s23c5_reg <= mulq(s23, c5);
            s23s4_reg <= mulq(s23, s4);
            s1_1_reg  <= s1;
            c1_1_reg  <= c1;
            s23_1_reg <= s23;
            c23_1_reg <= c23;
            s4_1_reg  <= s4;
            c5_1_reg  <= c5;
            rhs_1_reg <= val_t'(cfg.reach) - val_t'(em2 >> 16);
            st_1_reg  <= {q3_neg, q5_neg};
            st5_1_reg <= abs_s5 < val_t'(cfg.pw_margin);
        end
    end

    // ---- layer 2: wrist point and second-order terms
    val_t dwv, dwh, abs_dwv, abs_dwh;
    logic [67:0] sqv_full, sqh_full;

    assign dwv      = c2l2_reg + c23l3_reg;
    assign dwh      = s2l2_reg + s23l3_reg;
    assign abs_dwv  = (dwv < 0) ? -dwv : dwv;
    assign abs_dwh  = (dwh < 0) ? -dwh : dwh;
    assign sqv_full = abs_dwv[33:0] * abs_dwv[33:0];
    assign sqh_full = abs_dwh[33:0] * abs_dwh[33:0];

    logic v2_reg;
    val_t dwh_2_reg, pwx_2_reg, pwy_2_reg, pwz_2_reg;
    val_t m1_2_reg, s23c5_2_reg, a04_2_reg, a14_2_reg, a15_2_reg, a25_2_reg;
    val_t c1s4s5_2_reg, s1c23l3_2_reg, c1c23l3_2_reg, s1dwv_2_reg, c1dwv_2_reg;
    val_t s23l3_2_reg, s1_2_reg, c1_2_reg, s1s23_2_reg, c1s23_2_reg, c23_2_reg;
    val_t s23s4_2_reg, rhs_2_reg;
    logic [52:0] sq_2_reg;
    logic [5:0]  st_2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dwh_2_reg     <= dwh;
            pwx_2_reg     <= -mulq(s1_1_reg, dwh);
            pwy_2_reg     <= mulq(c1_1_reg, dwh);
            pwz_2_reg     <= l1 + dwv;
            m1_2_reg      <= mulq(c23_1_reg, c4s5_reg);
            s23c5_2_reg   <= s23c5_reg;
            a04_2_reg     <= -c1c4_reg + mulq(s1c23_reg, s4_1_reg);
            a14_2_reg     <= -s1c4_reg - mulq(c1c23_reg, s4_1_reg);
            a15_2_reg     <= -mulq(s1_1_reg, s4s5_reg) + mulq(c4s5_reg, c1c23_reg)
                             + mulq(c1s23_reg, c5_1_reg);
            a25_2_reg     <= c23c5_reg - mulq(s23_1_reg, c4s5_reg);
            c1s4s5_2_reg  <= mulq(c1_1_reg, s4s5_reg);
            s1c23l3_2_reg <= mulq(s1c23_reg, l3);
            c1c23l3_2_reg <= mulq(c1c23_reg, l3);
            s1dwv_2_reg   <= mulq(s1_1_reg, dwv);
            c1dwv_2_reg   <= mulq(c1_1_reg, dwv);
            s23l3_2_reg   <= s23l3_reg;
            s1_2_reg      <= s1_1_reg;
            c1_2_reg      <= c1_1_reg;
            s1s23_2_reg   <= s1s23_reg;
            c1s23_2_reg   <= c1s23_reg;
            c23_2_reg     <= c23_1_reg;
            s23s4_2_reg   <= s23s4_reg;
            rhs_2_reg     <= rhs_1_reg;
            sq_2_reg      <= 53'(sqv_full >> 16) + 53'(sqh_full >> 16);
            st_2_reg[ST_BACKWARD] <= dwh < 0;
            st_2_reg[ST_FLIP]     <= st_1_reg[0];
            st_2_reg[ST_ELBOW]    <= st_1_reg[1];
            st_2_reg[ST_WRIST]    <= abs_dwh < val_t'(cfg.wab_margin);
            st_2_reg[ST_EXTENDED] <= 1'b0;
            st_2_reg[ST_PARALLEL] <= st5_1_reg;
        end
    end

    // ---- layer 3: terms on the wrist point, last angular entry
    logic v3_reg;
    val_t ang_reg [3][NROWS];
    val_t lin_reg [3][3];
    val_t pwx_3_reg, pwy_3_reg, pwz_3_reg;
    logic [5:0] st_3_reg;
    val_t s1pwz, c1pwz, base;

    assign s1pwz = mulq(s1_2_reg, pwz_2_reg);
    assign c1pwz = mulq(c1_2_reg, pwz_2_reg);
    assign base  = mulq(c1_2_reg, pwy_2_reg) - mulq(s1_2_reg, pwx_2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_reg[0][0] <= '0;
            ang_reg[0][1] <= -c1_2_reg;
            ang_reg[0][2] <= -c1_2_reg;
            ang_reg[0][3] <= -s1s23_2_reg;
            ang_reg[0][4] <= a04_2_reg;
            ang_reg[0][5] <= -mulq(s1_2_reg, m1_2_reg + s23c5_2_reg) - c1s4s5_2_reg;
            ang_reg[1][0] <= '0;
            ang_reg[1][1] <= -s1_2_reg;
            ang_reg[1][2] <= -s1_2_reg;
            ang_reg[1][3] <= c1s23_2_reg;
            ang_reg[1][4] <= a14_2_reg;
            ang_reg[1][5] <= a15_2_reg;
            ang_reg[2][0] <= ONE_V;
            ang_reg[2][1] <= '0;
            ang_reg[2][2] <= '0;
            ang_reg[2][3] <= c23_2_reg;
            ang_reg[2][4] <= s23s4_2_reg;
            ang_reg[2][5] <= a25_2_reg;
            // joint one linear x/y terms cancel exactly
            lin_reg[0][0] <= '0;
            lin_reg[0][1] <= s1pwz - s1dwv_2_reg;
            lin_reg[0][2] <= s1pwz - s1c23l3_2_reg;
            lin_reg[1][0] <= '0;
            lin_reg[1][1] <= -c1pwz + c1dwv_2_reg;
            lin_reg[1][2] <= -c1pwz + c1c23l3_2_reg;
            lin_reg[2][0] <= '0;
            lin_reg[2][1] <= base - dwh_2_reg;
            lin_reg[2][2] <= base - s23l3_2_reg;
            pwx_3_reg     <= pwx_2_reg;
            pwy_3_reg     <= pwy_2_reg;
            pwz_3_reg     <= pwz_2_reg;
            st_3_reg      <= {st_2_reg[ST_PARALLEL],
                              $signed({1'b0, sq_2_reg}) > rhs_2_reg,
                              st_2_reg[ST_WRIST:ST_BACKWARD]};
        end
    end

    // ---- layer 4: wrist-joint linear columns, rounding and saturation
    logic v4_reg;
    logic [ENTRY_WIDTH-1:0] ent_reg  [NROWS][NROWS];
    logic [ENTRY_WIDTH-1:0] ent_next [NROWS][NROWS];
    logic [5:0] st_4_reg;

    always_comb
    begin
        for (int k = 0; k < NROWS; k++)
        begin
            if (k < 3)
            begin
                ent_next[0][k] = sat(lin_reg[0][k]);
                ent_next[1][k] = sat(lin_reg[1][k]);
                ent_next[2][k] = sat(lin_reg[2][k]);
            end
            else
            begin
                ent_next[0][k] = sat(-mulq(ang_reg[2][k], pwy_3_reg)
                                     + mulq(ang_reg[1][k], pwz_3_reg));
                ent_next[1][k] = sat(-mulq(ang_reg[0][k], pwz_3_reg)
                                     + mulq(ang_reg[2][k], pwx_3_reg));
                ent_next[2][k] = sat(-mulq(ang_reg[1][k], pwx_3_reg)
                                     + mulq(ang_reg[0][k], pwy_3_reg));
            end
            for (int r = 0; r < 3; r++)
                ent_next[r+3][k] = sat((ang_reg[r][k] + val_t'(8192)) >>> 14);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ent_reg  <= ent_next;
            st_4_reg <= st_3_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign ent       = ent_reg;
    assign status    = st_4_reg;

endmodule

[rtl/core/srj_row_out.sv]
// Row buffer: holds one finished Jacobian and hands it out a row per transfer.
// Depends on srj_pkg and assert_macros.svh.
`include "assert_macros.svh"
module srj_row_out
    import srj_pkg::*;
#(
    parameter int ENTRY_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          load_valid,
    input  logic [ENTRY_WIDTH-1:0]        ent [NROWS][NROWS],
    input  logic [5:0]                    status,
    output logic                          buf_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    row_index,
    output logic signed [ENTRY_WIDTH-1:0] col0,
    output logic signed [ENTRY_WIDTH-1:0] col1,
    output logic signed [ENTRY_WIDTH-1:0] col2,
    output logic signed [ENTRY_WIDTH-1:0] col3,
    output logic signed [ENTRY_WIDTH-1:0] col4,
    output logic signed [ENTRY_WIDTH-1:0] col5,
    output logic [5:0]                    status_bits,
    output logic                          singular,
    output logic                          last_row
);

    logic                   full_reg;
    logic [2:0]             row_reg;
    logic [ENTRY_WIDTH-1:0] ent_reg [NROWS][NROWS];
    logic [5:0]             st_reg;
    logic                   load;

    // a new set may land in the cycle the last row leaves
    assign buf_ready = !full_reg || (out_ready && row_reg == LAST_ROW);
    assign load      = load_valid && buf_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            row_reg  <= '0;
        end
        else if (load)
        begin
            full_reg <= 1'b1;
            row_reg  <= '0;
        end
        else if (full_reg && out_ready)
        begin
            if (row_reg == LAST_ROW)
                full_reg <= 1'b0;
            else
                row_reg <= row_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ent_reg <= ent;
            st_reg  <= status;
        end
    end

    assign out_valid   = full_reg;
    assign row_index   = row_reg;
    assign col0        = ent_reg[row_reg][0];
    assign col1        = ent_reg[row_reg][1];
    assign col2        = ent_reg[row_reg][2];
    assign col3        = ent_reg[row_reg][3];
    assign col4        = ent_reg[row_reg][4];
    assign col5        = ent_reg[row_reg][5];
    assign status_bits = st_reg;
    assign singular    = |st_reg[ST_PARALLEL:ST_WRIST];
    assign last_row    = row_reg == LAST_ROW;

    `SRJ_ASSERT(a_row_in_range, clk, rst_n, !full_reg || row_reg <= LAST_ROW)
    `SRJ_ASSERT_NEXT(a_stall_holds, clk, rst_n, full_reg && !out_ready,
        full_reg && $stable(row_reg))
    `SRJ_ASSERT_NEXT(a_drain_empties, clk, rst_n,
        full_reg && out_ready && row_reg == LAST_ROW && !load_valid, !full_reg)
    `SRJ_ASSERT_NEXT(a_row_steps, clk, rst_n,
        full_reg && out_ready && row_reg != LAST_ROW, row_reg == $past(row_reg) + 3'd1)

endmodule

[rtl/core/six_revolute_arm_jacobian.sv]
// Velocity Jacobian of a six-revolute arm: five CORDIC lanes, a merge stage
// and a row buffer. Depends on srj_pkg, srj_cordic_lane, srj_jacobian and
// srj_row_out.
//
// One joint-angle set is taken per transfer and comes out as six row
// transfers, rows 0..5, one per cycle while out_ready is high. The input
// pipeline takes a new set every cycle while in_ready is high; the single
// row buffer drains one row per cycle while out_ready is high, so it holds
// each set for six row transfers. On its way to the first row a set passes
// the sine/cosine lanes, the four product layers of the merge stage and
// one load into the row buffer. When a finished set waits on a busy row
// buffer the whole pipeline holds and in_ready drops.
// Configuration writes are always taken (cfg_ready is high); indexes past
// the last register are ignored.
module six_revolute_arm_jacobian
    import srj_pkg::*;
#(
    parameter int ENTRY_WIDTH  = 32,
    parameter int ANGLE_WIDTH  = 32,
    parameter int CORDIC_STEPS = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [ANGLE_WIDTH-1:0] joint1_angle,
    input  logic signed [ANGLE_WIDTH-1:0] joint2_angle,
    input  logic signed [ANGLE_WIDTH-1:0] joint3_angle,
    input  logic signed [ANGLE_WIDTH-1:0] joint4_angle,
    input  logic signed [ANGLE_WIDTH-1:0] joint5_angle,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    row_index,
    output logic signed [ENTRY_WIDTH-1:0] col0,
    output logic signed [ENTRY_WIDTH-1:0] col1,
    output logic signed [ENTRY_WIDTH-1:0] col2,
    output logic signed [ENTRY_WIDTH-1:0] col3,
    output logic signed [ENTRY_WIDTH-1:0] col4,
    output logic signed [ENTRY_WIDTH-1:0] col5,
    output logic [5:0]                    status_bits,
    output logic                          singular,
    output logic                          last_row
);

    localparam int LANE_LAT = CORDIC_STEPS + 2;
    localparam int NLANES   = 5;

    typedef struct packed {
        logic valid;
        logic q3_neg;
        logic q5_neg;
    } side_t;

    function automatic logic signed [AQ_W-1:0] to_q32(logic [ANGLE_WIDTH-1:0] raw);
        return AQ_W'($signed({raw, {(AQ_W - 1 - ANGLE_WIDTH){1'b0}}}));
    endfunction

    cfg_t  cfg_reg;
    side_t side_reg [LANE_LAT];
    logic  en;
    logic  jac_valid;
    logic  buf_ready;
    logic signed [AQ_W-1:0] lane_in [NLANES];
    unit_t lane_sin [NLANES];
    unit_t lane_cos [NLANES];
    trig_t trig;
    logic [ENTRY_WIDTH-1:0] ent [NROWS][NROWS];
    logic [5:0] status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.l1         <= '0;
            cfg_reg.l2         <= '0;
            cfg_reg.l3         <= '0;
            cfg_reg.reach      <= 31'd2147483647;
            cfg_reg.wab_margin <= 31'd655;
            cfg_reg.ext_margin <= 31'd655;
            cfg_reg.pw_margin  <= 31'd10737418;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BASE_HEIGHT:   cfg_reg.l1         <= cfg_data[30:0];
                REG_UPPER_ARM:     cfg_reg.l2         <= cfg_data[30:0];
                REG_FOREARM:       cfg_reg.l3         <= cfg_data[30:0];
                REG_REACH_LIMIT:   cfg_reg.reach      <= cfg_data[30:0];
                REG_WRIST_MARGIN:  cfg_reg.wab_margin <= cfg_data[30:0];
                REG_EXT_MARGIN:    cfg_reg.ext_margin <= cfg_data[30:0];
                REG_PARALLEL_MARG: cfg_reg.pw_margin  <= cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // whole pipeline moves together; it holds only when a finished set waits
    assign en       = buf_ready || !jac_valid;
    assign in_ready = en;

    always_comb
    begin
        lane_in[0] = to_q32(joint1_angle);
        lane_in[1] = to_q32(joint2_angle);
        lane_in[2] = to_q32(joint2_angle) + to_q32(joint3_angle);
        lane_in[3] = to_q32(joint4_angle);
        lane_in[4] = to_q32(joint5_angle);
    end

    for (genvar g = 0; g < NLANES; g++)
    begin : g_lane
        srj_cordic_lane #(
            .STEPS   (CORDIC_STEPS)
        ) u_lane (
            .clk     (clk),
            .en      (en),
            .angle   (lane_in[g]),
            .sin_val (lane_sin[g]),
            .cos_val (lane_cos[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LANE_LAT; i++)
                side_reg[i] <= '0;
        end
        else if (en)
        begin
            side_reg[0] <= '{valid: in_valid,
                             q3_neg: joint3_angle[ANGLE_WIDTH-1],
                             q5_neg: joint5_angle[ANGLE_WIDTH-1]};
            for (int i = 1; i < LANE_LAT; i++)
                side_reg[i] <= side_reg[i-1];
        end
    end

    always_comb
    begin
        trig.s1  = lane_sin[0];
        trig.c1  = lane_cos[0];
        trig.s2  = lane_sin[1];
        trig.c2  = lane_cos[1];
        trig.s23 = lane_sin[2];
        trig.c23 = lane_cos[2];
        trig.s4  = lane_sin[3];
        trig.c4  = lane_cos[3];
        trig.s5  = lane_sin[4];
        trig.c5  = lane_cos[4];
    end

    srj_jacobian #(
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_jac (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (side_reg[LANE_LAT-1].valid),
        .trig      (trig),
        .q3_neg    (side_reg[LANE_LAT-1].q3_neg),
        .q5_neg    (side_reg[LANE_LAT-1].q5_neg),
        .cfg       (cfg_reg),
        .out_valid (jac_valid),
        .ent       (ent),
        .status    (status)
    );

    srj_row_out #(
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_rows (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (jac_valid),
        .ent         (ent),
        .status      (status),
        .buf_ready   (buf_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .row_index   (row_index),
        .col0        (col0),
        .col1        (col1),
        .col2        (col2),
        .col3        (col3),
        .col4        (col4),
        .col5        (col5),
        .status_bits (status_bits),
        .singular    (singular),
        .last_row    (last_row)
    );

endmodule
